FILE: rtl/u8san_pkg.sv
// Package: payload types and constants for the UTF-8 stream sanitizer.
`timescale 1ns / 1ps
package u8san_pkg;

  localparam logic [23:0] REPL_WORD_RST = 24'hEFBFBD;

  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_CODE = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_CODE = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_CODE = 8'hF0;
  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_CODE  = 8'h80;

  localparam logic [15:0] CP3_MIN   = 16'h0800;
  localparam logic [15:0] SURR_LO   = 16'hD800;
  localparam logic [15:0] SURR_HI   = 16'hDFFF;
  localparam logic [20:0] CP4_MIN   = 21'h010000;
  localparam logic [20:0] CP4_MAX   = 21'h10FFFF;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       stream_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       replaced;
    logic       run_last;
  } out_item_t;

endpackage

FILE: rtl/utf8_stream_sanitizer_top.sv
// Top: UTF-8 validation with replacement word, one output byte per cycle unless stalled.
`timescale 1ns / 1ps
// Takes a UTF-8 byte stream one item per cycle and emits sanitized bytes one per cycle.
// Well-formed sequences pass unchanged once complete; each rejected byte becomes the three
// bytes of the replacement word (cfg_wdata, first byte in bits 23:16). All rates here hold
// only while out_stall is low. An item is parsed combinationally against the up to three
// pending bytes, so items that give one output byte each stream at one item per cycle. An
// item that gives k output bytes (0 to 12) holds the output sequencer until all k are out,
// as the single output port moves one byte per cycle; a next item that emits bytes waits under in_stall.
module utf8_stream_sanitizer_top
  import u8san_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_item,
  input  logic        cfg_we,
  input  logic [23:0] cfg_wdata
);

  logic [23:0] repl_r;

  logic        s1_valid_r;
  in_item_t    s1_item_r;

  logic [7:0]  pend_r [3];
  logic [1:0]  pend_cnt_r;
  logic [7:0]  pend_nxt [3];
  logic [1:0]  pend_cnt_nxt;

  logic [7:0]  bufw [4];
  logic [2:0]  nbuf;
  logic [3:0]  rep_nxt;
  logic [2:0]  num_nxt;

  logic [7:0]  plan_byte_r [4];
  logic [3:0]  plan_rep_r;
  logic [2:0]  plan_num_r;
  logic [1:0]  plan_pos_r;
  logic [1:0]  plan_sub_r;
  logic        plan_valid_r;

  logic        out_valid_r;
  out_item_t   out_item_r;

  logic        out_load;
  logic        entry_end;
  logic        plan_done;
  logic        plan_free;
  logic        s1_adv;
  logic        in_acc;
  out_item_t   emit_item;

  function automatic logic is_cont(input logic [7:0] b);
    return (b & CONT_MASK) == CONT_CODE;
  endfunction

  // working buffer: pending bytes then the new byte
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (i < 32'(pend_cnt_r)) begin
        bufw[i] = pend_r[i[1:0]];
      end else if (i == 32'(pend_cnt_r)) begin
        bufw[i] = s1_item_r.in_byte;
      end else begin
        bufw[i] = 8'h00;
      end
    end
    nbuf = {1'b0, pend_cnt_r} + 3'd1;
  end

  always_comb begin : parse
    logic [2:0]  hd;
    logic [2:0]  av;
    logic [2:0]  need;
    logic        stop;
    logic        ok;
    logic        waiting;
    logic [7:0]  c0;
    logic [7:0]  b1;
    logic [7:0]  b2;
    logic [7:0]  b3;
    logic [15:0] cp3;
    logic [20:0] cp4;
    logic [2:0]  rest;
    hd      = 3'd0;
    stop    = 1'b0;
    waiting = 1'b0;
    rep_nxt = 4'b0000;
    need    = 3'd0;
    ok      = 1'b0;
    av      = 3'd0;
    c0      = 8'h00;
    b1      = 8'h00;
    b2      = 8'h00;
    b3      = 8'h00;
    cp3     = 16'h0000;
    cp4     = 21'h000000;
    for (int s = 0; s < 4; s++) begin
      if (!stop && hd < nbuf) begin
        c0 = bufw[hd[1:0]];
        b1 = bufw[hd[1:0] + 2'd1];
        b2 = bufw[hd[1:0] + 2'd2];
        b3 = bufw[hd[1:0] + 2'd3];
        av = nbuf - hd;
        if (!c0[7]) begin
          need = 3'd1;
        end else if ((c0 & LEAD2_MASK) == LEAD2_CODE) begin
          need = 3'd2;
        end else if ((c0 & LEAD3_MASK) == LEAD3_CODE) begin
          need = 3'd3;
        end else if ((c0 & LEAD4_MASK) == LEAD4_CODE) begin
          need = 3'd4;
        end else begin
          need = 3'd0;
        end
        ok = (need != 3'd0);
        if (need > 3'd1 && av > 3'd1 && !is_cont(b1)) ok = 1'b0;
        if (need > 3'd2 && av > 3'd2 && !is_cont(b2)) ok = 1'b0;
        if (need > 3'd3 && av > 3'd3 && !is_cont(b3)) ok = 1'b0;
        if (ok && av < need) begin
          if (s1_item_r.stream_end) begin
            ok = 1'b0;
          end else begin
            waiting = 1'b1;
            stop    = 1'b1;
          end
        end
        cp3 = {c0[3:0], b1[5:0], b2[5:0]};
        cp4 = {c0[2:0], b1[5:0], b2[5:0], b3[5:0]};
        if (!stop) begin
          if (ok && need == 3'd2) begin
            ok = (c0[4:1] != 4'd0);
          end else if (ok && need == 3'd3) begin
            ok = (cp3 >= CP3_MIN) && !(cp3 >= SURR_LO && cp3 <= SURR_HI);
          end else if (ok && need == 3'd4) begin
            ok = (cp4 >= CP4_MIN) && (cp4 <= CP4_MAX);
          end
          if (ok) begin
            hd = hd + need;
          end else begin
            rep_nxt[hd[1:0]] = 1'b1;
            hd = hd + 3'd1;
          end
        end
      end
    end
    num_nxt = hd;
    rest    = nbuf - hd;
    pend_cnt_nxt = waiting ? rest[1:0] : 2'd0;
    for (int i = 0; i < 3; i++) begin
      pend_nxt[i] = bufw[hd[1:0] + i[1:0]];
    end
  end

  // output sequencer
  always_comb begin
    entry_end = !plan_rep_r[plan_pos_r] || (plan_sub_r == 2'd2);
    emit_item.replaced = plan_rep_r[plan_pos_r];
    emit_item.run_last = entry_end && ({1'b0, plan_pos_r} == plan_num_r - 3'd1);
    if (plan_rep_r[plan_pos_r]) begin
      case (plan_sub_r)
        2'd0:    emit_item.out_byte = repl_r[23:16];
        2'd1:    emit_item.out_byte = repl_r[15:8];
        default: emit_item.out_byte = repl_r[7:0];
      endcase
    end else begin
      emit_item.out_byte = plan_byte_r[plan_pos_r];
    end
  end

  assign out_load  = plan_valid_r && (!out_valid_r || !out_stall);
  assign plan_done = out_load && emit_item.run_last;
  assign plan_free = !plan_valid_r || plan_done;
  assign s1_adv    = s1_valid_r && (num_nxt == 3'd0 || plan_free);
  assign in_stall  = s1_valid_r && !s1_adv;
  assign in_acc    = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      repl_r <= REPL_WORD_RST;
    end else if (cfg_we) begin
      repl_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      pend_cnt_r <= 2'd0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        pend_cnt_r <= pend_cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r <= in_item;
    end
    if (s1_adv) begin
      for (int i = 0; i < 3; i++) begin
        pend_r[i] <= pend_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plan_valid_r <= 1'b0;
      plan_pos_r   <= 2'd0;
      plan_sub_r   <= 2'd0;
    end else if (s1_adv && num_nxt != 3'd0) begin
      plan_valid_r <= 1'b1;
      plan_pos_r   <= 2'd0;
      plan_sub_r   <= 2'd0;
    end else if (plan_done) begin
      plan_valid_r <= 1'b0;
      plan_pos_r   <= 2'd0;
      plan_sub_r   <= 2'd0;
    end else if (out_load) begin
      if (entry_end) begin
        plan_pos_r <= plan_pos_r + 2'd1;
        plan_sub_r <= 2'd0;
      end else begin
        plan_sub_r <= plan_sub_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && num_nxt != 3'd0) begin
      for (int i = 0; i < 4; i++) begin
        plan_byte_r[i] <= bufw[i];
      end
      plan_rep_r <= rep_nxt;
      plan_num_r <= num_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_item_r <= emit_item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_plan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    plan_valid_r |-> ({1'b0, plan_pos_r} < plan_num_r))
    else $error("plan position beyond emitted entries");

  a_sub_only_rep: assert property (@(posedge clk) disable iff (!rst_n)
    (plan_valid_r && plan_sub_r != 2'd0) |-> plan_rep_r[plan_pos_r])
    else $error("sub index advanced on a passed byte");

  a_end_flushes: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_item_r.stream_end) |=> (pend_cnt_r == 2'd0))
    else $error("pending bytes left after end of stream");

  a_adv_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && num_nxt != 3'd0) |-> plan_free)
    else $error("plan overwritten before drained");

endmodule
